FILE: hw/rtl/fpa_pkg.sv
// shared types and constants of the fixed pool free list allocator
`default_nettype none
package fpa_pkg;

  localparam int MAX_CHUNKS = 64;
  localparam int IDX_W      = $clog2(MAX_CHUNKS);
  localparam int CNT_W      = 7;
  localparam int SIZE_W     = 13;
  localparam int OFS_W      = 18;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_W      = 13;

  localparam logic [SIZE_W-1:0] MIN_CHUNK_BYTES = SIZE_W'(8);
  localparam logic [SIZE_W-1:0] MAX_CHUNK_BYTES = SIZE_W'(4096);

  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_COUNT = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE  = CFG_IDX_W'(1);

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_OOM   = 2'd1,
    ST_NULL  = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic commit;
  } cmd_t;

endpackage
`default_nettype wire

FILE: hw/rtl/fpa_ctrl.sv
// controller state machine of the pool allocator
`default_nettype none
module fpa_ctrl (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output fpa_pkg::cmd_t    cmd_o
);
  import fpa_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_stall_o = 1'b1;
    cmd_o      = '0;
    unique case (state_q)
      S_IDLE: begin
        in_stall_o   = 1'b0;
        cmd_o.accept = in_valid_i;
        if (in_valid_i) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        // finish once the output register is free or drains this cycle
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.commit = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    out_valid_d = cmd_o.commit | (out_valid_q & out_stall_i);
  end

  assign out_valid_o = out_valid_q;

endmodule
`default_nettype wire

FILE: hw/rtl/fpa_dp.sv
// datapath of the pool allocator: config, head, link memory, result register
`default_nettype none
module fpa_dp (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  fpa_pkg::cmd_t                         cmd_i,
  input  wire logic                             opcode_i,
  input  wire logic [fpa_pkg::IDX_W-1:0]        free_index_i,
  input  wire logic                             free_null_i,
  input  wire logic                             cfg_we_i,
  input  wire logic [fpa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [fpa_pkg::CFG_W-1:0]        cfg_wdata_i,
  output logic [1:0]                            status_o,
  output logic [fpa_pkg::IDX_W-1:0]             chunk_index_o,
  output logic [fpa_pkg::OFS_W-1:0]             byte_offset_o
);
  import fpa_pkg::*;

  logic [CNT_W-1:0]  count_q;
  logic [SIZE_W-1:0] size_q;
  logic [IDX_W-1:0]  head_q, head_d;
  logic              head_vld_q, head_vld_d;
  logic [MAX_CHUNKS-1:0] written_q;

  // link memory entry: {valid, next index}
  logic [IDX_W:0]    link_mem [MAX_CHUNKS];
  logic [IDX_W:0]    rd_link_q;
  logic              rd_written_q;

  op_e               op_q;
  logic [IDX_W-1:0]  idx_q;
  logic              null_q;

  logic [CNT_W-1:0]  eff_cnt;
  logic [SIZE_W-1:0] eff_size;
  logic [CNT_W-1:0]  head_plus1;
  logic [IDX_W:0]    next_link;
  logic [IDX_W+SIZE_W-1:0] product;
  logic              do_push;

  status_e           status_d;
  logic [IDX_W-1:0]  index_d;
  logic [OFS_W-1:0]  offset_d;
  status_e           status_q;
  logic [IDX_W-1:0]  index_q;
  logic [OFS_W-1:0]  offset_q;

  always_comb begin
    eff_cnt = count_q;
    if (count_q == '0) begin
      eff_cnt = CNT_W'(1);
    end else if (count_q > CNT_W'(MAX_CHUNKS)) begin
      eff_cnt = CNT_W'(MAX_CHUNKS);
    end
    eff_size = size_q;
    if (size_q < MIN_CHUNK_BYTES) begin
      eff_size = MIN_CHUNK_BYTES;
    end else if (size_q > MAX_CHUNK_BYTES) begin
      eff_size = MAX_CHUNK_BYTES;
    end
  end

  // entries never written since the last rebuild read as the chained order
  assign head_plus1 = CNT_W'(head_q) + CNT_W'(1);
  assign next_link  = rd_written_q ? rd_link_q
                    : (head_plus1 < eff_cnt) ? {1'b1, head_plus1[IDX_W-1:0]}
                    : '0;
  assign product    = (IDX_W+SIZE_W)'(head_q) * (IDX_W+SIZE_W)'(eff_size);

  always_comb begin
    status_d   = ST_OK;
    index_d    = '0;
    offset_d   = '0;
    head_d     = head_q;
    head_vld_d = head_vld_q;
    do_push    = 1'b0;
    if (op_q == OP_ALLOC) begin
      if (!head_vld_q) begin
        status_d = ST_OOM;
      end else begin
        index_d    = head_q;
        offset_d   = product[OFS_W-1:0];
        head_d     = next_link[IDX_W-1:0];
        head_vld_d = next_link[IDX_W];
      end
    end else if (null_q) begin
      status_d = ST_NULL;
    end else if (CNT_W'(idx_q) >= eff_cnt) begin
      status_d = ST_RANGE;
    end else begin
      do_push    = 1'b1;
      head_d     = idx_q;
      head_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= CNT_W'(64);
      size_q     <= SIZE_W'(32);
      head_q     <= '0;
      head_vld_q <= 1'b1;
      written_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_CHUNK_COUNT: count_q <= cfg_wdata_i[CNT_W-1:0];
        REG_CHUNK_SIZE:  size_q  <= cfg_wdata_i[SIZE_W-1:0];
        default: ;
      endcase
      head_q     <= '0;
      head_vld_q <= 1'b1;
      written_q  <= '0;
    end else if (cmd_i.commit) begin
      head_q     <= head_d;
      head_vld_q <= head_vld_d;
      if (do_push) begin
        written_q[idx_q] <= 1'b1;
      end
    end
  end

  // link memory: read at the head on accept, write on a push
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && do_push) begin
      link_mem[idx_q] <= {head_vld_q, head_q};
    end
    if (cmd_i.accept) begin
      rd_link_q    <= link_mem[head_q];
      rd_written_q <= written_q[head_q];
      op_q         <= op_e'(opcode_i);
      idx_q        <= free_index_i;
      null_q       <= free_null_i;
    end
    if (cmd_i.commit) begin
      status_q <= status_d;
      index_q  <= index_d;
      offset_q <= offset_d;
    end
  end

  assign status_o      = status_q;
  assign chunk_index_o = index_q;
  assign byte_offset_o = offset_q;

endmodule
`default_nettype wire

FILE: hw/rtl/fixed_pool_free_list_allocator.sv
// top level of the fixed pool free list allocator
// flow: a request beat is taken in the idle state, and its result beat is registered when the exec state ends,
//   which is held back only while an earlier result beat is still stalled
// a new request waits until the last one leaves exec, which uses the registered head link read
// reset: chunk count 64, chunk size 32, all chunks free and chained in index order
// a config write rebuilds the list at once through per-chunk written flags, no clearing pass
`default_nettype none
module fixed_pool_free_list_allocator (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic                             opcode_i,
  input  wire logic [fpa_pkg::IDX_W-1:0]        free_index_i,
  input  wire logic                             free_null_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic [1:0]                            status_o,
  output logic [fpa_pkg::IDX_W-1:0]             chunk_index_o,
  output logic [fpa_pkg::OFS_W-1:0]             byte_offset_o,
  input  wire logic                             cfg_we_i,
  input  wire logic [fpa_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [fpa_pkg::CFG_W-1:0]        cfg_wdata_i
);
  import fpa_pkg::*;

  cmd_t cmd;

  fpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  fpa_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .opcode_i      (opcode_i),
    .free_index_i  (free_index_i),
    .free_null_i   (free_null_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .status_o      (status_o),
    .chunk_index_o (chunk_index_o),
    .byte_offset_o (byte_offset_o)
  );

endmodule
`default_nettype wire
